### src/ising_pkg.sv
// ising_pkg: lattice size, derived widths, opcodes and register indexes
// for the Metropolis update block. No dependencies.
`default_nettype none

package ising_pkg;

  // Lattice side length; the lattice is SIDE x SIDE with periodic wrap.
  localparam int SIDE  = 32;
  localparam int IDX_W = $clog2(SIDE);
  localparam int SITES = SIDE * SIDE;

  // Internal totals are exact; the ports carry them at their full width.
  localparam int MAG_W     = $clog2(SITES) + 2;
  localparam int ENG_W     = $clog2(SITES) + 3;
  localparam int OUT_MAG_W = 12;
  localparam int OUT_ENG_W = 13;

  localparam int PROB_W  = 32;
  localparam int SITE_IN_W = 5;

  typedef enum logic [1:0] {
    OP_MOVE = 2'd0,
    OP_FLIP = 2'd1,
    OP_READ = 2'd2,
    OP_SPARE = 2'd3   // behaves as a read
  } opcode_t;

  localparam logic REG_PROB_DE4 = 1'b0;
  localparam logic REG_PROB_DE8 = 1'b1;

  // Reduce a site coordinate modulo SIDE (small constant table).
  function automatic logic [IDX_W-1:0] wrap_index(input logic [SITE_IN_W-1:0] v);
    logic [IDX_W-1:0] res;
    res = '0;
    for (int i = 0; i < (1 << SITE_IN_W); i++) begin
      if (v == SITE_IN_W'(i)) begin
        res = IDX_W'(i % SIDE);
      end
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] prev_index(input logic [IDX_W-1:0] x);
    return (x == '0) ? IDX_W'(SIDE - 1) : x - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(SIDE - 1)) ? '0 : x + IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

### src/ising_metropolis_update.sv
// ising_metropolis_update: single-site Metropolis update on a periodic
// spin lattice kept in a row-wide memory. Depends on ising_pkg.
//
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  opcode, site_row, site_col, random_fraction
// out       source     out_valid / out_stall flipped, spin_now, total_magnetization,
//                                           total_energy
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// Sequence: the lattice memory has one read port; the row above,
//   the row below and the site's own row are read in turn (one per cycle),
//   then the update cycle evaluates and writes the row back.
// Reset: sync, active high. Afterwards a clear pass writes all-up rows, one
//   row per cycle, until every row is written; in_stall stays high meanwhile.
// Stalls: a finished result sits in the output register; a new item is
//   taken while it waits. The update cycle holds only if the output
//   register is still full and stalled.
`default_nettype none

module ising_metropolis_update (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration
  input  wire logic                                   cfg_we,
  input  wire logic                                   cfg_index,
  input  wire logic [ising_pkg::PROB_W-1:0]           cfg_data,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             opcode,
  input  wire logic [ising_pkg::SITE_IN_W-1:0]        site_row,
  input  wire logic [ising_pkg::SITE_IN_W-1:0]        site_col,
  input  wire logic [ising_pkg::PROB_W-1:0]           random_fraction,
  // output channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        flipped,
  output logic                                        spin_now,
  output logic signed [ising_pkg::OUT_MAG_W-1:0]      total_magnetization,
  output logic signed [ising_pkg::OUT_ENG_W-1:0]      total_energy
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RD_DN  = 5'b00100,  // up row arriving, request row below
    ST_RD_MID = 5'b01000,  // down row arriving, request own row
    ST_EVAL   = 5'b10000   // own row present: decide, write back, report
  } state_t;

  state_t state, state_next;

  // config registers
  logic [ising_pkg::PROB_W-1:0] prob_de4, prob_de8;

  // item registers
  logic [ising_pkg::IDX_W-1:0]  row_q, col_q;
  logic [1:0]                   op_q;
  logic [ising_pkg::PROB_W-1:0] rnd_q;
  logic                         up_bit, dn_bit;

  // lattice memory: one word per row, one bit per column
  logic [ising_pkg::SIDE-1:0]   lattice_mem [ising_pkg::SIDE];
  logic [ising_pkg::SIDE-1:0]   rd_data;
  logic [ising_pkg::IDX_W-1:0]  rd_addr;
  logic                         mem_we;
  logic [ising_pkg::IDX_W-1:0]  mem_waddr;
  logic [ising_pkg::SIDE-1:0]   mem_wdata;
  logic [ising_pkg::IDX_W-1:0]  clr_cnt;

  // running totals (exact)
  logic [ising_pkg::MAG_W-1:0]  magnetization, magnetization_next;
  logic [ising_pkg::ENG_W-1:0]  energy, energy_next;

  logic                         in_xfer, fire;
  logic [ising_pkg::IDX_W-1:0]  row_in, col_in;
  logic                         spin_old, left_bit, right_bit;
  logic [2:0]                   aligned;
  logic [ising_pkg::PROB_W-1:0] prob_sel;
  logic                         prob_hit, do_flip;
  logic [ising_pkg::SIDE-1:0]   col_mask;
  logic [ising_pkg::ENG_W-1:0]  eng_delta;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign fire     = (state == ST_EVAL) && !(out_valid && out_stall);

  assign row_in = ising_pkg::wrap_index(site_row);
  assign col_in = ising_pkg::wrap_index(site_col);

  // read address walks up row, down row, own row
  always_comb begin
    case (state)
      ST_IDLE:   rd_addr = ising_pkg::prev_index(row_in);
      ST_RD_DN:  rd_addr = ising_pkg::next_index(row_q);
      ST_RD_MID: rd_addr = row_q;
      ST_EVAL:   rd_addr = row_q;
      default:   rd_addr = row_q;
    endcase
  end

  // evaluation on the own row word
  assign spin_old  = rd_data[col_q];
  assign left_bit  = rd_data[ising_pkg::prev_index(col_q)];
  assign right_bit = rd_data[ising_pkg::next_index(col_q)];
  assign aligned   = 3'(up_bit == spin_old) + 3'(dn_bit == spin_old)
                   + 3'(left_bit == spin_old) + 3'(right_bit == spin_old);

  // dE = 4*aligned - 8; flips freely for aligned <= 2
  assign prob_sel = (aligned == 3'd4) ? prob_de8 : prob_de4;
  assign prob_hit = prob_sel > rnd_q;

  always_comb begin
    case (op_q)
      ising_pkg::OP_FLIP: do_flip = 1'b1;
      ising_pkg::OP_MOVE: do_flip = (aligned <= 3'd2) || prob_hit;
      default:            do_flip = 1'b0;
    endcase
  end

  assign eng_delta = ising_pkg::ENG_W'({aligned, 2'b00}) - ising_pkg::ENG_W'(8);

  always_comb begin
    magnetization_next = magnetization;
    energy_next        = energy;
    if (do_flip) begin
      magnetization_next = spin_old ? magnetization - ising_pkg::MAG_W'(2)
                                    : magnetization + ising_pkg::MAG_W'(2);
      energy_next        = energy + eng_delta;
    end
  end

  always_comb begin
    col_mask        = '0;
    col_mask[col_q] = 1'b1;
  end

  // single write port: clear pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = rd_data;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '1;
    end else if (fire && do_flip) begin
      mem_we    = 1'b1;
      mem_wdata = rd_data ^ col_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= lattice_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == ising_pkg::IDX_W'(ising_pkg::SIDE - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_xfer) state_next = ST_RD_DN;
      ST_RD_DN:  state_next = ST_RD_MID;
      ST_RD_MID: state_next = ST_EVAL;
      ST_EVAL:   if (fire) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      prob_de4      <= '0;
      prob_de8      <= '0;
      magnetization <= ising_pkg::MAG_W'(ising_pkg::SITES);
      energy        <= ising_pkg::ENG_W'(-2 * ising_pkg::SITES);
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ising_pkg::IDX_W'(1);
      end
      if (cfg_we) begin
        if (cfg_index == ising_pkg::REG_PROB_DE4) begin
          prob_de4 <= cfg_data;
        end else begin
          prob_de8 <= cfg_data;
        end
      end
      if (fire) begin
        magnetization <= magnetization_next;
        energy        <= energy_next;
        out_valid     <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      row_q <= row_in;
      col_q <= col_in;
      op_q  <= opcode;
      rnd_q <= random_fraction;
    end
    if (state == ST_RD_DN) begin
      up_bit <= rd_data[col_q];
    end
    if (state == ST_RD_MID) begin
      dn_bit <= rd_data[col_q];
    end
    if (fire) begin
      flipped             <= do_flip;
      spin_now            <= spin_old ^ do_flip;
      total_magnetization <= magnetization_next[ising_pkg::OUT_MAG_W-1:0];
      total_energy        <= energy_next[ising_pkg::OUT_ENG_W-1:0];
    end
  end

  // an accepted item reaches the update cycle after exactly three reads
  a_item_seq: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ##3 (state == ST_EVAL))
    else $error("item did not reach update cycle on schedule");

  // a reported flip moves the magnetization, a non-flip leaves it
  a_flip_mag: assert property (@(posedge clk) disable iff (rst)
    fire |=> ((magnetization != $past(magnetization)) == flipped))
    else $error("magnetization change disagrees with flipped");

  // magnetization stays within the lattice size
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(magnetization) <= $signed(ising_pkg::MAG_W'(ising_pkg::SITES))) &&
    ($signed(magnetization) >= $signed(ising_pkg::MAG_W'(-ising_pkg::SITES))))
    else $error("magnetization out of range");

  // clear pass only ends after the last row
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_CLEAR && state == ST_IDLE) |->
      ($past(clr_cnt) == ising_pkg::IDX_W'(ising_pkg::SIDE - 1)))
    else $error("clear pass ended early");

endmodule

`default_nettype wire
